@@ sv/aes128_ecb_pkcs7_codec_defines.svh @@
// ----------------------------------------------------------------------------
// AES codec assertion macros
// Shared assertion forms for the codec top level.
// ----------------------------------------------------------------------------
`ifndef AES128_ECB_PKCS7_CODEC_DEFINES_SVH
`define AES128_ECB_PKCS7_CODEC_DEFINES_SVH
`define AES_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define AES_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

@@ sv/aes_pkg.sv @@
// ----------------------------------------------------------------------------
// AES codec package
// Payload types, constants and byte-level AES functions.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam logic [63:0] KEY_HIGH_RESET = 64'd3544952156018063160;
  localparam logic [63:0] KEY_LOW_RESET  = 64'd4120847750721124662;
  localparam int RK_DEPTH = 22;
  localparam int ROUNDS = 10;
  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  typedef struct packed {
    logic        command;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic [4:0]  byte_count;
    logic        last_block;
  } in_t;

  typedef struct packed {
    logic [63:0] out_high;
    logic [63:0] out_low;
    logic [4:0]  valid_bytes;
    logic        last_result;
    logic        pad_error;
  } out_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] inv_sbox(input logic [7:0] v);
    logic [7:0] r;
    r = 8'h00;
    for (int x = 0; x < 256; x++) begin
      if (SBOX[x] == v) r = 8'(x);
    end
    return r;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] bt(input logic [127:0] s, input int k);
    return s[127-8*k -: 8];
  endfunction

  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        t[127-8*(k+4*c) -: 8] = SBOX[bt(s, k + 4 * ((c + k) & 3))];
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = bt(t, 4*c); a1 = bt(t, 4*c+1); a2 = bt(t, 4*c+2); a3 = bt(t, 4*c+3);
        t[127-32*c -: 32] = {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                             a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                             a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                             xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, u, v;
    for (int c = 0; c < 4; c++) begin
      a0 = bt(s, 4*c); a1 = bt(s, 4*c+1); a2 = bt(s, 4*c+2); a3 = bt(s, 4*c+3);
      u = xt(xt(a0 ^ a2));
      v = xt(xt(a1 ^ a3));
      a0 = a0 ^ u; a1 = a1 ^ v; a2 = a2 ^ u; a3 = a3 ^ v;
      u = a0 ^ a1 ^ a2 ^ a3;
      t[127-32*c -: 32] = {a0 ^ u ^ xt(a0 ^ a1), a1 ^ u ^ xt(a1 ^ a2),
                           a2 ^ u ^ xt(a2 ^ a3), a3 ^ u ^ xt(a3 ^ a0)};
    end
    return t;
  endfunction

  function automatic logic [127:0] dec_sub(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        t[127-8*(k+4*((c+k)&3)) -: 8] = inv_sbox(bt(s, k + 4*c));
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] next_key(input logic [127:0] w, input logic [7:0] rc);
    logic [31:0] t;
    logic [127:0] n;
    t = {SBOX[w[23:16]] ^ rc, SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
    n[127:96] = w[127:96] ^ t;
    n[95:64] = w[95:64] ^ n[127:96];
    n[63:32] = w[63:32] ^ n[95:64];
    n[31:0] = w[31:0] ^ n[63:32];
    return n;
  endfunction

endpackage

@@ sv/aes_ram.sv @@
// ----------------------------------------------------------------------------
// AES generic RAM
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module aes_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ sv/aes128_ecb_pkcs7_codec.sv @@
// ----------------------------------------------------------------------------
// AES-128 ECB codec with PKCS#7 padding
// Iterative single-round AES core with a round key RAM.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall carries command, block, byte count and
// last flag; output channel out_valid/out_stall carries one result block.
// From accept to out_valid an item passes the initial key addition, ten
// rounds through one shared round unit and the output register load.
// Each round key is read from the RAM in the state before its use.
// A full last encrypt block runs the core twice: after the first result
// a key read state (S_RD) starts the same steps again for the pad block.
// in_stall stays high while an item is in work, so no new item is taken
// until the last one is loaded into the output register. A new item is
// accepted while a result waits; it runs its rounds and then holds until
// the output register is free. A stalled result holds until taken.
// Round keys come from one key-schedule step per cycle into an 11-entry
// RAM. After reset, and after every key register write, the schedule runs
// with in_stall high.
`include "aes128_ecb_pkcs7_codec_defines.svh"
module aes128_ecb_pkcs7_codec #(
  parameter logic [63:0] KEY_HIGH_RESET = aes_pkg::KEY_HIGH_RESET,
  parameter logic [63:0] KEY_LOW_RESET  = aes_pkg::KEY_LOW_RESET
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  aes_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output aes_pkg::out_t out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);
  localparam logic [2:0] S_EXP = 3'd0, S_IDLE = 3'd1, S_RD = 3'd2, S_INIT = 3'd3,
                         S_RND = 3'd4, S_OUT = 3'd5;
  localparam logic [3:0] REG_HIGH = 4'd0, REG_LOW = 4'd8;

  logic [2:0]   state;
  logic [63:0]  key_high, key_low;
  logic [127:0] kw;
  logic [3:0]   kcnt;
  logic [7:0]   rc;
  logic [3:0]   rnd;
  logic [3:0]   raddr;
  logic [127:0] rk, st, st_next;
  logic         cmd, second, lastb;
  logic [4:0]   cnt;
  logic         cfg_wr;
  logic         key_we;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr == REG_HIGH) ? key_high : (paddr == REG_LOW) ? key_low : 64'd0;
  assign key_we = (state == S_EXP);

  aes_ram #(.WIDTH(128), .DEPTH(aes_pkg::RK_DEPTH / 2)) u_rk (
    .clk(clk), .we(key_we), .waddr(kcnt), .wdata(kw), .raddr(raddr), .rdata(rk)
  );

  assign in_stall = (state != S_IDLE);
  assign raddr = (state == S_IDLE) ? ((in_data.command == aes_pkg::CMD_DECRYPT) ? 4'd10 : 4'd0)
               : (state == S_RD) ? ((cmd == aes_pkg::CMD_DECRYPT) ? 4'd10 : 4'd0)
               : (state == S_INIT) ? ((cmd == aes_pkg::CMD_DECRYPT) ? 4'd9 : 4'd1)
               : (cmd == aes_pkg::CMD_DECRYPT) ? 4'd8 - rnd : rnd + 4'd2;

  always_comb begin
    if (cmd == aes_pkg::CMD_DECRYPT) begin
      st_next = aes_pkg::dec_sub(st) ^ rk;
      if (rnd != 4'd9) st_next = aes_pkg::inv_mix(st_next);
    end else begin
      st_next = aes_pkg::enc_round(st, rnd == 4'd9) ^ rk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_EXP;
      key_high <= KEY_HIGH_RESET;
      key_low <= KEY_LOW_RESET;
      kw <= {KEY_HIGH_RESET, KEY_LOW_RESET};
      kcnt <= 4'd0;
      rc <= 8'h01;
      out_valid <= 1'b0;
      second <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_wr && (paddr == REG_HIGH || paddr == REG_LOW)) begin
        if (paddr == REG_HIGH) begin
          key_high <= pwdata;
          kw <= {pwdata, key_low};
        end else begin
          key_low <= pwdata;
          kw <= {key_high, pwdata};
        end
        kcnt <= 4'd0;
        rc <= 8'h01;
        state <= S_EXP;
      end else begin
        unique case (state)
          S_EXP: begin
            kw <= aes_pkg::next_key(kw, rc);
            rc <= aes_pkg::xt(rc);
            kcnt <= kcnt + 4'd1;
            if (kcnt == 4'd10) state <= S_IDLE;
          end
          S_IDLE: begin
            if (in_valid) begin
              cmd <= in_data.command;
              lastb <= in_data.last_block;
              cnt <= (in_data.byte_count > 5'd16) ? 5'd16 : in_data.byte_count;
              st <= {in_data.block_high, in_data.block_low};
              second <= 1'b0;
              state <= S_INIT;
            end
          end
          S_RD: state <= S_INIT;
          S_INIT: begin
            if (cmd == aes_pkg::CMD_ENCRYPT && lastb && cnt < 5'd16 && !second) begin
              for (int k = 0; k < 16; k++) begin
                if (k >= int'(cnt)) st[127-8*k -: 8] <= 8'(16 - int'(cnt)) ^ rk[127-8*k -: 8];
                else st[127-8*k -: 8] <= st[127-8*k -: 8] ^ rk[127-8*k -: 8];
              end
            end else begin
              st <= st ^ rk;
            end
            rnd <= 4'd0;
            state <= S_RND;
          end
          S_RND: begin
            st <= st_next;
            rnd <= rnd + 4'd1;
            if (rnd == 4'd9) state <= S_OUT;
          end
          S_OUT: begin
            if (!out_valid || !out_stall) begin
              out_valid <= 1'b1;
              out_data.out_high <= st[127:64];
              out_data.out_low <= st[63:0];
              out_data.valid_bytes <= 5'd16;
              out_data.pad_error <= 1'b0;
              out_data.last_result <= 1'b1;
              state <= S_IDLE;
              if (cmd == aes_pkg::CMD_DECRYPT && lastb) begin
                if (st[7:0] > 8'd16) begin
                  out_data.valid_bytes <= 5'd0;
                  out_data.pad_error <= 1'b1;
                end else begin
                  out_data.valid_bytes <= 5'(8'd16 - st[7:0]);
                end
              end
              if (cmd == aes_pkg::CMD_ENCRYPT && lastb && cnt == 5'd16 && !second) begin
                out_data.last_result <= 1'b0;
                second <= 1'b1;
                st <= {16{8'h10}};
                state <= S_RD;
              end
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  `AES_ASSERT_IMP(a_no_accept_busy, in_valid && !in_stall, state == S_IDLE)
  `AES_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `AES_ASSERT_IMP(a_rnd_range, state == S_RND, rnd <= 4'd9)
endmodule
